// ===== hw/rtl/fbcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fbcm_pkg;

  // Width of one table entry and of the block fields.
  localparam int unsigned ENTRY_W = 10;

  // Entry codes: a free block and the end of a chain.
  localparam logic [ENTRY_W-1:0] ENTRY_FREE = '0;
  localparam logic [ENTRY_W-1:0] END_MARK   = '1;

  // Reset value of the first data block register.
  localparam logic [8:0] FIRST_DATA_RST = 9'd8;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  // Status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BROKEN = 2'd2,
    STAT_RANGE  = 2'd3
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_SCAN   = 11'b000_0000_0100,
    S_LINK   = 11'b000_0000_1000,
    S_MARK   = 11'b000_0001_0000,
    S_FR_RD  = 11'b000_0010_0000,
    S_FR_CHK = 11'b000_0100_0000,
    S_RD_ISS = 11'b000_1000_0000,
    S_RD_CAP = 11'b001_0000_0000,
    S_WR     = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/fat_block_chain_manager_top.sv =====
// File allocation table manager. One command item enters on the s_axis channel
// and exactly one response item leaves on the m_axis channel. The table lives
// in a single memory with one write and one registered read port, driven by a
// small sequencer; s_axis_tready is high only while the sequencer is idle.
// Steps per command: read issues a table read and captures the entry; write
// stores the entry; out-of-range and empty-chain commands go straight to the
// response; allocate scans from first_data_block upward, one entry scanned per
// cycle, then links the tail (if there is one) and marks the new block as the
// end, or reports full when no free block is found; free chain does a read and
// a clear per link, and stops with an error on a free entry. The next command
// can be accepted once the sequencer is back in idle, which it enters as the
// response register is loaded.
// After reset the block clears the whole table, one entry a cycle; no command
// is accepted during that pass, but configuration writes are.
// first_data_block resets to 8.
// The response sits in an output register. If the receiver stalls, the next
// command is still accepted and processed, and it waits in its final state
// until the previous response has been taken.
`timescale 1ns / 1ps
`default_nettype none

module fat_block_chain_manager_top
  import fbcm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 512
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: first_data_block.
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  // Command items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [9:0] block, [19:10] value, [23:20] zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] op
  // Response items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [9:0] result_block, [19:10] freed_count,
                                          // [23:20] zero
  output logic [1:0]       m_axis_tuser   // [1:0] status
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned SW = AW + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
  localparam logic [SW-1:0] SCAN_END  = SW'(TABLE_ENTRIES);

  // True when a signed block number addresses an entry of the table.
  function automatic logic in_table(input logic [ENTRY_W-1:0] b);
    return !b[ENTRY_W-1] && (32'(b[ENTRY_W-2:0]) < TABLE_ENTRIES);
  endfunction

  // Table address of a block number already known to be in range.
  function automatic logic [AW-1:0] to_addr(input logic [ENTRY_W-1:0] b);
    return AW'(b[ENTRY_W-2:0]);
  endfunction

  state_e              state_q, state_d;
  logic [8:0]          first_q;
  logic [AW-1:0]       clr_q, clr_d;
  logic [ENTRY_W-1:0]  blk_q, blk_d;
  logic [ENTRY_W-1:0]  val_q, val_d;
  logic [AW-1:0]       cur_q, cur_d;
  logic [AW-1:0]       chk_q, chk_d;
  logic                pend_q, pend_d;
  logic [SW-1:0]       scan_q, scan_d;
  logic [SW-1:0]       steps_q, steps_d;
  logic [SW-1:0]       steps_nx;
  logic [1:0]          stat_q, stat_d;
  logic [ENTRY_W-1:0]  res_q, res_d;
  logic [ENTRY_W-1:0]  freed_q, freed_d;
  logic                out_valid_q, out_valid_d;
  logic [1:0]          out_stat_q, out_stat_d;
  logic [ENTRY_W-1:0]  out_res_q, out_res_d;
  logic [ENTRY_W-1:0]  out_freed_q, out_freed_d;

  // Table memory and its port controls.
  logic [ENTRY_W-1:0]  mem_q [TABLE_ENTRIES];
  logic [ENTRY_W-1:0]  rdata_q;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  logic                accept;
  logic [ENTRY_W-1:0]  in_blk;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_blk        = s_axis_tdata[ENTRY_W-1:0];
  assign steps_nx      = steps_q + SW'(1);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {4'b0, out_freed_q, out_res_q};

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Read address follows the state that needs the data.
  always_comb begin
    case (state_q)
      S_SCAN:  rd_addr = scan_q[AW-1:0];
      default: rd_addr = cur_q;
    endcase
  end

  // Write port selection.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = ENTRY_FREE;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
      end
      S_LINK: begin
        wr_en   = 1'b1;
        wr_addr = to_addr(blk_q);
        wr_data = res_q;
      end
      S_MARK: begin
        wr_en   = 1'b1;
        wr_addr = chk_q;
        wr_data = END_MARK;
      end
      S_FR_CHK: begin
        wr_en = (rdata_q != ENTRY_FREE);
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = to_addr(blk_q);
        wr_data = val_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    blk_d       = blk_q;
    val_d       = val_q;
    cur_d       = cur_q;
    chk_d       = chk_q;
    pend_d      = pend_q;
    scan_d      = scan_q;
    steps_d     = steps_q;
    stat_d      = stat_q;
    res_d       = res_q;
    freed_d     = freed_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_res_d   = out_res_q;
    out_freed_d = out_freed_q;

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          blk_d   = in_blk;
          val_d   = s_axis_tdata[2*ENTRY_W-1:ENTRY_W];
          cur_d   = to_addr(in_blk);
          pend_d  = 1'b0;
          steps_d = '0;
          stat_d  = STAT_OK;
          res_d   = END_MARK;
          freed_d = '0;
          if (32'(first_q) >= TABLE_ENTRIES) begin
            scan_d = SCAN_END;
          end else begin
            scan_d = SW'(first_q);
          end
          case (op_e'(s_axis_tuser))
            OP_ALLOC: begin
              if (in_blk != END_MARK && !in_table(in_blk)) begin
                stat_d  = STAT_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_FREE: begin
              if (in_blk == END_MARK) begin
                state_d = S_DONE;
              end else if (!in_table(in_blk)) begin
                stat_d  = STAT_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_FR_RD;
              end
            end
            OP_READ: begin
              if (!in_table(in_blk)) begin
                stat_d  = STAT_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_RD_ISS;
              end
            end
            default: begin
              if (!in_table(in_blk)) begin
                stat_d  = STAT_RANGE;
                state_d = S_DONE;
              end else begin
                state_d = S_WR;
              end
            end
          endcase
        end
      end

      // One read issued and one entry checked per cycle.
      S_SCAN: begin
        if (pend_q && rdata_q == ENTRY_FREE) begin
          res_d = ENTRY_W'(chk_q);
          if (blk_q != END_MARK) begin
            state_d = S_LINK;
          end else begin
            state_d = S_MARK;
          end
        end else if (32'(scan_q) < TABLE_ENTRIES) begin
          chk_d  = scan_q[AW-1:0];
          pend_d = 1'b1;
          scan_d = scan_q + SW'(1);
        end else begin
          stat_d  = STAT_FULL;
          state_d = S_DONE;
        end
      end

      S_LINK: begin
        state_d = S_MARK;
      end

      S_MARK: begin
        state_d = S_DONE;
      end

      S_FR_RD: begin
        state_d = S_FR_CHK;
      end

      // The entry read is cleared here; the walk then follows its link.
      S_FR_CHK: begin
        if (rdata_q == ENTRY_FREE) begin
          stat_d  = STAT_BROKEN;
          state_d = S_DONE;
        end else begin
          steps_d = steps_nx;
          if (freed_q != '1) begin
            freed_d = freed_q + ENTRY_W'(1);
          end
          if (rdata_q == END_MARK) begin
            state_d = S_DONE;
          end else if (!in_table(rdata_q) || 32'(steps_nx) == TABLE_ENTRIES) begin
            stat_d  = STAT_BROKEN;
            state_d = S_DONE;
          end else begin
            cur_d   = to_addr(rdata_q);
            state_d = S_FR_RD;
          end
        end
      end

      S_RD_ISS: begin
        state_d = S_RD_CAP;
      end

      S_RD_CAP: begin
        res_d   = rdata_q;
        state_d = S_DONE;
      end

      S_WR: begin
        state_d = S_DONE;
      end

      // Hand the response to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_stat_d  = stat_q;
          out_res_d   = res_q;
          out_freed_d = freed_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      first_q     <= FIRST_DATA_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        first_q <= cfg_wdata_i;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    blk_q       <= blk_d;
    val_q       <= val_d;
    cur_q       <= cur_d;
    chk_q       <= chk_d;
    pend_q      <= pend_d;
    scan_q      <= scan_d;
    steps_q     <= steps_d;
    stat_q      <= stat_d;
    res_q       <= res_d;
    freed_q     <= freed_d;
    out_stat_q  <= out_stat_d;
    out_res_q   <= out_res_d;
    out_freed_q <= out_freed_d;
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_fat_block_chain_manager_top.sv =====
`timescale 1ns / 1ps

module tb_fat_block_chain_manager_top;
  import fbcm_pkg::*;

  localparam int TABLE_ENTRIES = 512;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 8;
  localparam int N_FILES       = 6;
  localparam int MAX_FILE_LEN  = 24;

  // One response item as the block should deliver it.
  typedef struct packed {
    status_e            status;
    logic [ENTRY_W-1:0] result;
    logic [ENTRY_W-1:0] freed;
  } fat_resp_t;

  // Shadow allocation table plus the queue of responses still owed by the block.
  class fat_table_model;
    logic [ENTRY_W-1:0] fat_entry [TABLE_ENTRIES];
    logic [8:0]         first_block;
    fat_resp_t          pending_resp [$];
    int unsigned        err_cnt;

    function new();
      foreach (fat_entry[i]) fat_entry[i] = ENTRY_FREE;
      first_block = FIRST_DATA_RST;
      err_cnt = 0;
    endfunction

    function bit in_table(int b);
      return b >= 0 && b < TABLE_ENTRIES;
    endfunction

    // Apply one accepted command to the shadow table and queue its response.
    function fat_resp_t apply_command(op_e op, logic [ENTRY_W-1:0] blk,
                                      logic [ENTRY_W-1:0] val);
      fat_resp_t          r;
      int                 b;
      int                 cur;
      int                 nxt;
      int                 slot;
      int                 steps;
      logic [ENTRY_W-1:0] e;
      bit                 found;
      bit                 walking;
      b = int'($signed(blk));
      r.status = STAT_OK;
      r.result = END_MARK;
      r.freed  = '0;
      case (op)
        OP_ALLOC: begin
          if (b != -1 && !in_table(b)) begin
            r.status = STAT_RANGE;
          end else begin
            found = 1'b0;
            slot  = 0;
            for (int i = first_block; i < TABLE_ENTRIES && !found; i++) begin
              if (fat_entry[i] == ENTRY_FREE) begin
                found = 1'b1;
                slot  = i;
              end
            end
            if (!found) begin
              r.status = STAT_FULL;
            end else begin
              // Link first, then mark, so a free tail equal to the new block ends the chain.
              if (b != -1) fat_entry[b] = ENTRY_W'(slot);
              fat_entry[slot] = END_MARK;
              r.result = ENTRY_W'(slot);
            end
          end
        end
        OP_FREE: begin
          if (b == -1) begin
            r.status = STAT_OK;
          end else if (!in_table(b)) begin
            r.status = STAT_RANGE;
          end else begin
            // Walk and clear until the end mark, a free entry, a bad link or the size limit.
            r.status = STAT_BROKEN;
            cur      = b;
            steps    = 0;
            walking  = 1'b1;
            while (walking && steps < TABLE_ENTRIES) begin
              e = fat_entry[cur];
              if (e == ENTRY_FREE) begin
                walking = 1'b0;
              end else begin
                nxt = int'($signed(e));
                fat_entry[cur] = ENTRY_FREE;
                steps++;
                if (r.freed < 10'd1023) r.freed = r.freed + 1'b1;
                if (nxt == -1) begin
                  r.status = STAT_OK;
                  walking  = 1'b0;
                end else if (!in_table(nxt)) begin
                  walking = 1'b0;
                end else begin
                  cur = nxt;
                end
              end
            end
          end
        end
        OP_READ: begin
          if (!in_table(b)) r.status = STAT_RANGE;
          else r.result = fat_entry[b];
        end
        default: begin
          if (!in_table(b)) r.status = STAT_RANGE;
          else fat_entry[b] = val;
        end
      endcase
      pending_resp.push_back(r);
      return r;
    endfunction

    // Compare one delivered response with the oldest one owed.
    function void check_response(logic [1:0] status, logic [ENTRY_W-1:0] result,
                                 logic [ENTRY_W-1:0] freed);
      fat_resp_t want;
      if (pending_resp.size() == 0) begin
        $error("response with none expected: status %0d result_block %0d freed_count %0d",
               status, $signed(result), freed);
        err_cnt++;
      end else begin
        want = pending_resp.pop_front();
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status);
          err_cnt++;
        end
        if (result !== want.result) begin
          $error("result_block mismatch: expected %0d, got %0d",
                 $signed(want.result), $signed(result));
          err_cnt++;
        end
        if (freed !== want.freed) begin
          $error("freed_count mismatch: expected %0d, got %0d", want.freed, freed);
          err_cnt++;
        end
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  fat_table_model fat_model;

  // Traffic shaping for the sender and the receiver.
  bit tx_idle_en    = 1'b1;
  bit rx_idle_en    = 1'b1;
  bit long_hold_req = 1'b0;

  // Open files built up by the random part: first block, last block and length.
  int file_head [N_FILES];
  int file_tail [N_FILES];
  int file_len  [N_FILES];

  fat_block_chain_manager_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock generation.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Idle lengths: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Offer one command item and hold it until the block takes it.
  task automatic send_cmd(input op_e op, input logic [ENTRY_W-1:0] blk,
                          input logic [ENTRY_W-1:0] val, output fat_resp_t want);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, val, blk};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    want = fat_model.apply_command(op, blk, val);
    if (tx_idle_en && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and let every owed response come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (fat_model.pending_resp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Change the lowest allocatable block while the block is idle.
  task automatic set_first_block(input logic [8:0] v);
    wait_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    fat_model.first_block = v;
    cfg_we_i <= 1'b0;
  endtask

  // Mostly file-like traffic: grow chains, free them, read links; the rest is noise.
  task automatic run_random(input int n);
    fat_resp_t          r;
    int                 pick;
    int                 s;
    op_e                op;
    logic [ENTRY_W-1:0] blk;
    logic [ENTRY_W-1:0] val;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      s    = $urandom_range(0, N_FILES - 1);
      val  = ENTRY_W'($urandom());
      if (file_len[s] >= MAX_FILE_LEN) pick = 40;
      if (pick < 35) begin
        op  = OP_ALLOC;
        blk = ENTRY_W'(file_tail[s]);
      end else if (pick < 55) begin
        op  = OP_FREE;
        blk = ENTRY_W'(file_head[s]);
      end else if (pick < 75) begin
        op  = OP_READ;
        blk = pick[0] ? ENTRY_W'(file_tail[s]) : ENTRY_W'($urandom_range(0, 511));
      end else if (pick < 85) begin
        op  = OP_WRITE;
        blk = ENTRY_W'($urandom_range(0, 511));
        case ($urandom_range(0, 3))
          0:       val = ENTRY_FREE;
          1:       val = END_MARK;
          2:       val = ENTRY_W'($urandom_range(1, 511));
          default: val = ENTRY_W'($urandom());
        endcase
      end else begin
        op  = op_e'($urandom_range(0, 3));
        blk = ENTRY_W'($urandom());
      end
      send_cmd(op, blk, val, r);
      // Track the files that the well-formed commands touched.
      if (pick < 35 && r.status == STAT_OK) begin
        if (file_head[s] < 0) file_head[s] = int'($signed(r.result));
        file_tail[s] = int'($signed(r.result));
        file_len[s]++;
      end else if (pick >= 35 && pick < 55) begin
        file_head[s] = -1;
        file_tail[s] = -1;
        file_len[s]  = 0;
      end
    end
  endtask

  // Receiver: random back-pressure, plus one long hold on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
        gap = pick_gap();
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check every response item taken from the block.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      fat_model.check_response(m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[19:10]);
    end
  end

  // Watchdog.
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb_fat_block_chain_manager_top failed");
        $finish;
      end
    end
  end

  // Main sequence.
  initial begin
    fat_resp_t r;
    fat_model = new();
    foreach (file_head[i]) begin
      file_head[i] = -1;
      file_tail[i] = -1;
      file_len[i]  = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset value of the first data block.
    send_cmd(OP_READ,  10'd0,    10'd0,    r);
    send_cmd(OP_READ,  10'd511,  10'd0,    r);
    send_cmd(OP_READ,  END_MARK, 10'd0,    r);  // no entry -1
    send_cmd(OP_READ,  10'h200,  10'd0,    r);  // most negative block
    send_cmd(OP_WRITE, END_MARK, 10'd5,    r);
    send_cmd(OP_WRITE, 10'd511,  10'h200,  r);  // raw pattern stored as is
    send_cmd(OP_READ,  10'd511,  10'd0,    r);
    send_cmd(OP_FREE,  END_MARK, 10'd0,    r);  // empty chain
    send_cmd(OP_FREE,  10'h3FE,  10'd0,    r);  // start out of range
    send_cmd(OP_FREE,  10'd511,  10'd0,    r);  // link out of range
    send_cmd(OP_FREE,  10'd511,  10'd0,    r);  // starts on a free entry
    send_cmd(OP_ALLOC, END_MARK, 10'd0,    r);
    send_cmd(OP_ALLOC, 10'd8,    10'd0,    r);
    send_cmd(OP_ALLOC, 10'd9,    10'd0,    r);
    send_cmd(OP_ALLOC, 10'h2D4,  10'd0,    r);  // tail out of range
    send_cmd(OP_ALLOC, 10'd11,   10'd0,    r);  // free tail that is the block found
    send_cmd(OP_WRITE, 10'd10,   10'd11,   r);
    send_cmd(OP_FREE,  10'd8,    10'd0,    r);
    send_cmd(OP_WRITE, 10'd20,   10'd20,   r);  // self loop
    send_cmd(OP_FREE,  10'd20,   10'd0,    r);
    send_cmd(OP_WRITE, 10'd30,   10'd511,  r);
    send_cmd(OP_WRITE, 10'd511,  END_MARK, r);
    send_cmd(OP_FREE,  10'd30,   10'd0,    r);
    send_cmd(OP_ALLOC, 10'd5,    10'd0,    r);  // tail below the data area
    send_cmd(OP_FREE,  10'd5,    10'd0,    r);

    // Highest first data block: one block left, then a full table.
    set_first_block(9'd511);
    send_cmd(OP_ALLOC, END_MARK, 10'd0, r);
    send_cmd(OP_ALLOC, END_MARK, 10'd0, r);
    send_cmd(OP_ALLOC, 10'd511,  10'd0, r);
    send_cmd(OP_READ,  10'd511,  10'd0, r);
    send_cmd(OP_FREE,  10'd511,  10'd0, r);

    // Lowest first data block: one chain through every entry that loops back,
    // so the table is full and the free stops at the size limit.
    set_first_block(9'd0);
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      send_cmd(OP_WRITE, ENTRY_W'(i), ENTRY_W'(i + 1), r);
    end
    send_cmd(OP_WRITE, ENTRY_W'(TABLE_ENTRIES - 1), 10'd1, r);
    send_cmd(OP_ALLOC, END_MARK, 10'd0, r);
    send_cmd(OP_FREE,  10'd0,    10'd0, r);
    send_cmd(OP_READ,  10'd0,    10'd0, r);

    // Random phases over several settings.
    set_first_block(FIRST_DATA_RST);
    run_random(150);

    set_first_block(9'd0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(100);

    // Long receiver hold while commands keep coming, then a full pause.
    set_first_block(9'd100);
    long_hold_req = 1'b1;
    run_random(12);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_drained();
    run_random(130);

    set_first_block(9'($urandom_range(0, 300)));
    run_random(120);

    set_first_block(9'd3);
    rx_idle_en = 1'b0;
    run_random(50);
    rx_idle_en = 1'b1;
    run_random(50);

    wait_drained();
    if (fat_model.err_cnt == 0 && fat_model.pending_resp.size() == 0) begin
      $display("tb_fat_block_chain_manager_top passed");
    end else begin
      $display("tb_fat_block_chain_manager_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fbcm_pkg.sv
hw/rtl/fat_block_chain_manager_top.sv
tb/sv/tb_fat_block_chain_manager_top.sv
